FILE: design/mp2d_pkg.sv
`default_nettype none

package mp2d_pkg;

	// Fixed widths of the result coordinates and the row counter
	localparam int ROW_W = 8;
	localparam int OUT_W = 8;

	// Common width for position and size compares
	localparam int CMP_W = 16;

	// Upper limits that do not follow from the parameters
	localparam int MAX_HEIGHT = 256;
	localparam int MAX_STEP   = 8;

	// Depth of the queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;

	// Configuration register indexes
	localparam logic [2:0] REG_PLANE_WIDTH  = 3'd0;
	localparam logic [2:0] REG_PLANE_HEIGHT = 3'd1;
	localparam logic [2:0] REG_WINDOW_WIDTH = 3'd2;
	localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd3;
	localparam logic [2:0] REG_STEP_X       = 3'd4;
	localparam logic [2:0] REG_STEP_Y       = 3'd5;

	// Classification of one sample, passed from front to back
	typedef struct packed {
		logic             close;
		logic             plane_end;
		logic [OUT_W-1:0] out_col;
		logic [OUT_W-1:0] out_row;
	} mp2d_tag_t;

	// Back part sequencer
	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_DRAIN
	} mp2d_bstate_t;

endpackage

`default_nettype wire

FILE: design/max_pool_2d_stream_core.sv
`default_nettype none

// Streaming 2-D max pooling over one feature-map plane at a time.
// Input: samples in raster order, written with push while full is low.
// Output: one beat per closed window (pooled_max, out_col, out_row, plane_end),
// shown while empty is low and taken with pop.
// Config: cfg_we with cfg_index 0..5 (plane width, plane height, window width,
// window height, step x, step y) and cfg_data; any known index restarts the plane.
// Write registers only while the block is idle.
// Throughput: the front takes one beat per cycle into a four-entry queue while full
// is low. The back pops non-closing samples without a sweep; for a closing sample it
// sweeps one window column per cycle across row-sliced line store banks and takes no
// new sample until the result is loaded into its output register.
// Path from a closing sample to its result: queue, column sweep, result register.
// When the receiver stalls, the back holds the finished result in its output
// register and parks; the queue keeps taking samples until it fills, then full rises.
// Reset: registers go to 8x8 plane, 2x2 window, stride 2; positions go to zero;
// the line store is not cleared and needs no clearing pass.
module max_pool_2d_stream_core #(
	parameter int MAX_WIDTH   = 256,
	parameter int MAX_WINDOW  = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [2:0]             cfg_index,
	input  wire logic [8:0]             cfg_data,
	input  wire logic                   push,
	output      logic                   full,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	output      logic                   empty,
	input  wire logic                   pop,
	output      logic [SAMPLE_BITS-1:0] pooled_max,
	output      logic [7:0]             out_col,
	output      logic [7:0]             out_row,
	output      logic                   plane_end
);
	import mp2d_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int SLOT_W = $clog2(MAX_WINDOW);
	localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
	localparam int ENT_W  = $bits(mp2d_tag_t) + COL_W + SLOT_W + SAMPLE_BITS;

	logic                   f_push;
	mp2d_tag_t              f_tag;
	logic [COL_W-1:0]       f_col;
	logic [SLOT_W-1:0]      f_slot;
	logic [SAMPLE_BITS-1:0] f_sample;
	logic [WIN_W-1:0]       ww;
	logic [WIN_W-1:0]       wh;

	logic                   q_full;
	logic                   q_empty;
	logic                   q_pop;
	logic [ENT_W-1:0]       q_wdata;
	logic [ENT_W-1:0]       q_rdata;

	mp2d_tag_t              b_tag;
	logic [COL_W-1:0]       b_col;
	logic [SLOT_W-1:0]      b_slot;
	logic [SAMPLE_BITS-1:0] b_sample;

	assign full    = q_full;
	assign q_wdata = {f_tag, f_col, f_slot, f_sample};
	assign {b_tag, b_col, b_slot, b_sample} = q_rdata;

	mp2d_front #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.sample    (sample),
		.q_full    (q_full),
		.q_push    (f_push),
		.q_tag     (f_tag),
		.q_col     (f_col),
		.q_slot    (f_slot),
		.q_sample  (f_sample),
		.ww        (ww),
		.wh        (wh)
	);

	mp2d_queue #(
		.DATA_W (ENT_W)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_push),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	mp2d_back #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.q_tag      (b_tag),
		.q_col      (b_col),
		.q_slot     (b_slot),
		.q_sample   (b_sample),
		.ww         (ww),
		.wh         (wh),
		.empty      (empty),
		.pop        (pop),
		.pooled_max (pooled_max),
		.out_col    (out_col),
		.out_row    (out_row),
		.plane_end  (plane_end)
	);

endmodule

`default_nettype wire

FILE: design/mp2d_front.sv
`default_nettype none

module mp2d_front #(
	parameter int MAX_WIDTH   = 256,
	parameter int MAX_WINDOW  = 8,
	parameter int SAMPLE_BITS = 16,
	localparam int COL_W  = $clog2(MAX_WIDTH),
	localparam int SLOT_W = $clog2(MAX_WINDOW),
	localparam int WIN_W  = $clog2(MAX_WINDOW + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [2:0]             cfg_index,
	input  wire logic [8:0]             cfg_data,
	input  wire logic                   push,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire logic                   q_full,
	output      logic                   q_push,
	output      mp2d_pkg::mp2d_tag_t    q_tag,
	output      logic [COL_W-1:0]       q_col,
	output      logic [SLOT_W-1:0]      q_slot,
	output      logic [SAMPLE_BITS-1:0] q_sample,
	output      logic [WIN_W-1:0]       ww,
	output      logic [WIN_W-1:0]       wh
);
	import mp2d_pkg::*;

	localparam int PW_W = COL_W + 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_WINDOW - 1);

	logic [PW_W-1:0]   pw_q;
	logic [8:0]        ph_q;
	logic [WIN_W-1:0]  ww_q;
	logic [WIN_W-1:0]  wh_q;
	logic [3:0]        sx_q;
	logic [3:0]        sy_q;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SLOT_W-1:0] slot_q;
	logic [2:0]        cph_q;
	logic [2:0]        rph_q;
	logic [OUT_W-1:0]  ocol_q;
	logic [OUT_W-1:0]  orow_q;

	logic              cfg_hit;
	logic              accept;
	logic [CMP_W-1:0]  c1;
	logic [CMP_W-1:0]  r1;
	logic              col_in;
	logic              row_in;
	logic              col_end;
	logic              row_end;
	logic              close;
	logic              last_x;
	logic              last_y;

	assign cfg_hit = cfg_we && (cfg_index <= REG_STEP_Y);
	assign accept  = push && !q_full;

	// Classify the sample at the current position
	always_comb begin
		c1      = CMP_W'(col_q) + CMP_W'(1);
		r1      = CMP_W'(row_q) + CMP_W'(1);
		col_in  = c1 >= CMP_W'(ww_q);
		row_in  = r1 >= CMP_W'(wh_q);
		col_end = c1 >= CMP_W'(pw_q);
		row_end = r1 >= CMP_W'(ph_q);
		close   = col_in && row_in && (cph_q == '0) && (rph_q == '0);
		last_x  = (CMP_W'(col_q) + CMP_W'(sx_q)) >= CMP_W'(pw_q);
		last_y  = (CMP_W'(row_q) + CMP_W'(sy_q)) >= CMP_W'(ph_q);
	end

	assign q_push           = accept;
	assign q_tag.close      = close;
	assign q_tag.plane_end  = close && last_x && last_y;
	assign q_tag.out_col    = ocol_q;
	assign q_tag.out_row    = orow_q;
	assign q_col            = col_q;
	assign q_slot           = slot_q;
	assign q_sample         = sample;
	assign ww               = ww_q;
	assign wh               = wh_q;

	// Write registers, saturating zero to one and large values to the limit; window and step use cfg_data[3:0]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_q <= PW_W'(8);
			ph_q <= 9'd8;
			ww_q <= WIN_W'(2);
			wh_q <= WIN_W'(2);
			sx_q <= 4'd2;
			sy_q <= 4'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PLANE_WIDTH: begin
					if (cfg_data == '0) pw_q <= PW_W'(1);
					else if (32'(cfg_data) > MAX_WIDTH) pw_q <= PW_W'(MAX_WIDTH);
					else pw_q <= PW_W'(cfg_data);
				end
				REG_PLANE_HEIGHT: begin
					if (cfg_data == '0) ph_q <= 9'd1;
					else if (32'(cfg_data) > MAX_HEIGHT) ph_q <= 9'(MAX_HEIGHT);
					else ph_q <= cfg_data;
				end
				REG_WINDOW_WIDTH: begin
					if (cfg_data[3:0] == '0) ww_q <= WIN_W'(1);
					else if (32'(cfg_data[3:0]) > MAX_WINDOW) ww_q <= WIN_W'(MAX_WINDOW);
					else ww_q <= WIN_W'(cfg_data[3:0]);
				end
				REG_WINDOW_HEIGHT: begin
					if (cfg_data[3:0] == '0) wh_q <= WIN_W'(1);
					else if (32'(cfg_data[3:0]) > MAX_WINDOW) wh_q <= WIN_W'(MAX_WINDOW);
					else wh_q <= WIN_W'(cfg_data[3:0]);
				end
				REG_STEP_X: begin
					if (cfg_data[3:0] == '0) sx_q <= 4'd1;
					else if (32'(cfg_data[3:0]) > MAX_STEP) sx_q <= 4'(MAX_STEP);
					else sx_q <= cfg_data[3:0];
				end
				REG_STEP_Y: begin
					if (cfg_data[3:0] == '0) sy_q <= 4'd1;
					else if (32'(cfg_data[3:0]) > MAX_STEP) sy_q <= 4'(MAX_STEP);
					else sy_q <= cfg_data[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Restart on a known config write; else advance position, stride phases and output counters per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
			cph_q  <= '0;
			rph_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (cfg_hit) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
			cph_q  <= '0;
			rph_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q  <= '0;
				cph_q  <= '0;
				ocol_q <= '0;
				if (row_end) begin
					row_q  <= '0;
					rph_q  <= '0;
					slot_q <= '0;
					orow_q <= '0;
				end else begin
					if (row_in) begin
						rph_q <= ((4'(rph_q) + 4'd1) >= sy_q) ? 3'd0 : rph_q + 3'd1;
					end
					if (row_in && (rph_q == '0)) begin
						orow_q <= orow_q + OUT_W'(1);
					end
					row_q  <= row_q + ROW_W'(1);
					slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
				if (col_in) begin
					cph_q <= ((4'(cph_q) + 4'd1) >= sx_q) ? 3'd0 : cph_q + 3'd1;
				end
				if (close) begin
					ocol_q <= ocol_q + OUT_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/mp2d_queue.sv
`default_nettype none

module mp2d_queue #(
	parameter int DATA_W = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [DATA_W-1:0] wr_data,
	output      logic              full,
	input  wire logic              rd_en,
	output      logic [DATA_W-1:0] rd_data,
	output      logic              empty
);
	import mp2d_pkg::*;

	logic [DATA_W-1:0]  data_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   cnt_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (cnt_q == (Q_PTR_W + 1)'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = data_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_wr) begin
			data_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			if (do_rd) rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			if (do_wr && !do_rd) cnt_q <= cnt_q + (Q_PTR_W + 1)'(1);
			else if (do_rd && !do_wr) cnt_q <= cnt_q - (Q_PTR_W + 1)'(1);
		end
	end

endmodule

`default_nettype wire

FILE: design/mp2d_back.sv
`default_nettype none

module mp2d_back #(
	parameter int MAX_WIDTH   = 256,
	parameter int MAX_WINDOW  = 8,
	parameter int SAMPLE_BITS = 16,
	localparam int COL_W  = $clog2(MAX_WIDTH),
	localparam int SLOT_W = $clog2(MAX_WINDOW),
	localparam int WIN_W  = $clog2(MAX_WINDOW + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_empty,
	output      logic                   q_pop,
	input  wire mp2d_pkg::mp2d_tag_t    q_tag,
	input  wire logic [COL_W-1:0]       q_col,
	input  wire logic [SLOT_W-1:0]      q_slot,
	input  wire logic [SAMPLE_BITS-1:0] q_sample,
	input  wire logic [WIN_W-1:0]       ww,
	input  wire logic [WIN_W-1:0]       wh,
	output      logic                   empty,
	input  wire logic                   pop,
	output      logic [SAMPLE_BITS-1:0] pooled_max,
	output      logic [7:0]             out_col,
	output      logic [7:0]             out_row,
	output      logic                   plane_end
);
	import mp2d_pkg::*;

	localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

	mp2d_bstate_t state_q;
	mp2d_bstate_t state_d;

	mp2d_tag_t              tag_q;
	logic [COL_W-1:0]       col_q;
	logic [MAX_WINDOW-1:0]  mask_q;
	logic [MAX_WINDOW-1:0]  mask_d;
	logic [SLOT_W-1:0]      x_q;
	logic [SAMPLE_BITS-1:0] max_q;
	logic [SAMPLE_BITS-1:0] fold;
	logic [SLOT_W:0]        slot_gap;

	logic                   rd_en;
	logic                   x_last;
	logic [COL_W-1:0]       rd_addr;
	logic                   rd_vld_s1;
	logic [SAMPLE_BITS-1:0] rd_data_s1 [MAX_WINDOW];

	logic                   out_load;
	logic                   res_vld_q;
	logic [SAMPLE_BITS-1:0] pooled_q;
	logic [OUT_W-1:0]       ocol_q;
	logic [OUT_W-1:0]       orow_q;
	logic                   pend_q;

	assign x_last  = (CMP_W'(x_q) + CMP_W'(1)) >= CMP_W'(ww);
	assign rd_addr = col_q - COL_W'(x_q);

	// Select the banks that hold the window's rows
	always_comb begin
		slot_gap = '0;
		mask_d   = '0;
		for (int b = 0; b < MAX_WINDOW; b++) begin
			slot_gap = (SLOT_W + 1)'(q_slot) + (SLOT_W + 1)'(MAX_WINDOW) - (SLOT_W + 1)'(b);
			if (slot_gap >= (SLOT_W + 1)'(MAX_WINDOW)) begin
				slot_gap = slot_gap - (SLOT_W + 1)'(MAX_WINDOW);
			end
			mask_d[b] = CMP_W'(slot_gap) < CMP_W'(wh);
		end
	end

	// One line store bank per row slot, one column read per cycle during the sweep
	for (genvar b = 0; b < MAX_WINDOW; b++) begin : g_bank
		logic [SAMPLE_BITS-1:0] mem [MAX_WIDTH];

		always_ff @(posedge clk) begin
			if (q_pop && (q_slot == SLOT_W'(b))) begin
				mem[q_col] <= q_sample;
			end
			if (rd_en) begin
				rd_data_s1[b] <= mem[rd_addr];
			end
		end
	end

	// Fold one column of the window into the running maximum
	always_comb begin
		fold = max_q;
		if (rd_vld_s1) begin
			for (int b = 0; b < MAX_WINDOW; b++) begin
				if (mask_q[b] && ($signed(rd_data_s1[b]) > $signed(fold))) begin
					fold = rd_data_s1[b];
				end
			end
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: take a beat, sweep window columns, hand over the result
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		rd_en    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (q_tag.close) state_d = B_READ;
				end
			end
			B_READ: begin
				rd_en = 1'b1;
				if (x_last) state_d = B_DRAIN;
			end
			B_DRAIN: begin
				if (!res_vld_q || pop) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Hold the current beat and the running maximum
	always_ff @(posedge clk) begin
		if (q_pop) begin
			tag_q  <= q_tag;
			col_q  <= q_col;
			mask_q <= mask_d;
			max_q  <= MOST_NEG;
			x_q    <= '0;
		end else begin
			if (rd_en) x_q <= x_q + SLOT_W'(1);
			if (rd_vld_s1) max_q <= fold;
		end
	end

	// Read valid and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (out_load) res_vld_q <= 1'b1;
			else if (pop) res_vld_q <= 1'b0;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			pooled_q <= fold;
			ocol_q   <= tag_q.out_col;
			orow_q   <= tag_q.out_row;
			pend_q   <= tag_q.plane_end;
		end
	end

	assign empty      = !res_vld_q;
	assign pooled_max = pooled_q;
	assign out_col    = ocol_q;
	assign out_row    = orow_q;
	assign plane_end  = pend_q;

`ifndef ASSERT_OFF
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue popped while empty");

	a_rd_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q == B_READ))
		else $error("read data valid without a read");

	a_x_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_READ) |-> (CMP_W'(x_q) < CMP_W'(ww)))
		else $error("column sweep past window width");

	a_mask_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_READ) |-> (mask_q != '0))
		else $error("no bank selected for window");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!res_vld_q || pop))
		else $error("result register overwritten");
`endif

endmodule

`default_nettype wire
